// ===== sv/cte_pkg.sv =====
// Shared types and constants for the CBOR token encoder.
`timescale 1ns / 1ps

package cte_pkg;

    localparam int KIND_W  = 4;
    localparam int VALUE_W = 64;
    localparam int BYTE_W  = 8;
    localparam int NB_W    = 4;
    localparam int IDX_W   = 3;

    localparam logic [KIND_W-1:0] KIND_INT       = 4'd0;
    localparam logic [KIND_W-1:0] KIND_FALSE     = 4'd1;
    localparam logic [KIND_W-1:0] KIND_TRUE      = 4'd2;
    localparam logic [KIND_W-1:0] KIND_NULL      = 4'd3;
    localparam logic [KIND_W-1:0] KIND_UNDEFINED = 4'd4;
    localparam logic [KIND_W-1:0] KIND_BYTES_HDR = 4'd5;
    localparam logic [KIND_W-1:0] KIND_TEXT_HDR  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_ARRAY_HDR = 4'd7;
    localparam logic [KIND_W-1:0] KIND_MAP_HDR   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 4'd9;

    localparam logic [2:0] MAJOR_UINT  = 3'd0;
    localparam logic [2:0] MAJOR_NINT  = 3'd1;
    localparam logic [2:0] MAJOR_BYTES = 3'd2;
    localparam logic [2:0] MAJOR_TEXT  = 3'd3;
    localparam logic [2:0] MAJOR_ARRAY = 3'd4;
    localparam logic [2:0] MAJOR_MAP   = 3'd5;

    localparam logic [4:0] AI_ARG1 = 5'h18;
    localparam logic [4:0] AI_ARG2 = 5'h19;
    localparam logic [4:0] AI_ARG4 = 5'h1a;
    localparam logic [4:0] AI_ARG8 = 5'h1b;

    localparam logic [VALUE_W-1:0] IMM_LIMIT  = 64'd24;
    localparam logic [VALUE_W-1:0] ARG1_LIMIT = 64'h100;
    localparam logic [VALUE_W-1:0] ARG2_LIMIT = 64'h10000;
    localparam logic [VALUE_W-1:0] ARG4_LIMIT = 64'h100000000;

    localparam logic [BYTE_W-1:0] SIMPLE_FALSE     = 8'hf4;
    localparam logic [BYTE_W-1:0] SIMPLE_TRUE      = 8'hf5;
    localparam logic [BYTE_W-1:0] SIMPLE_NULL      = 8'hf6;
    localparam logic [BYTE_W-1:0] SIMPLE_UNDEFINED = 8'hf7;

    typedef struct packed {
        logic [BYTE_W-1:0]  first;
        logic [VALUE_W-1:0] arg;
        logic [NB_W-1:0]    nbytes;
    } desc_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

    typedef enum logic {
        BK_HEAD,
        BK_ARG
    } back_state_t;

endpackage

// ===== sv/cbor_token_encoder_unit.sv =====
// Top level of the CBOR token encoder: front end, descriptor queue, serializer.
`timescale 1ns / 1ps

// Takes one token per item and emits its CBOR encoding one byte per item on the
// m_ channel, with m_last_byte on the final byte of each token. Single-byte
// tokens (simple values, payload bytes, small integers and counts) sustain one
// token per cycle while m_ready is high; a head with an argument occupies the
// serializer for its head byte and then its N argument bytes, N being 1, 2, 4
// or 8, since the output register takes at most one byte per cycle. A queue of
// QUEUE_DEPTH descriptors lets the input keep accepting while a long head drains.
// Kinds 10 to 15 are accepted and dropped; others go through the queue.
module cbor_token_encoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [cte_pkg::KIND_W-1:0]  s_kind,
    input  logic [cte_pkg::VALUE_W-1:0] s_int_value,
    input  logic [cte_pkg::VALUE_W-1:0] s_count,
    input  logic [cte_pkg::BYTE_W-1:0]  s_data_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cte_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                        m_last_byte
);

    cte_pkg::desc_t       front_desc, q_desc;
    cte_pkg::hs_t         push_hs, pop_hs;
    cte_pkg::back_state_t back_state;
    logic                 emits, q_pop, q_full;

    cte_front u_front (
        .kind      (s_kind),
        .int_value (s_int_value),
        .count     (s_count),
        .data_byte (s_data_byte),
        .emits     (emits),
        .desc      (front_desc)
    );

    assign push_hs.valid = s_valid && emits;
    assign push_hs.ready = 1'b1;

    cte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_hs_in (push_hs),
        .push_ready (s_ready),
        .push_desc  (front_desc),
        .pop_hs_out (pop_hs),
        .pop_ready  (q_pop),
        .pop_desc   (q_desc),
        .full       (q_full)
    );

    cte_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (pop_hs.valid),
        .q_pop       (q_pop),
        .q_desc      (q_desc),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte),
        .state       (back_state)
    );

`ifndef SYNTHESIS
    a_arg_pending : assert property (@(posedge aclk) disable iff (!aresetn)
        (back_state == cte_pkg::BK_ARG) |-> (m_valid && !m_last_byte))
        else $error("argument bytes pending but output shows none or a last byte");

    a_full_stalls : assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> (!s_ready && !pop_hs.ready))
        else $error("input ready while descriptor queue full");

    a_pop_loads : assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (m_valid && (m_out_byte == $past(q_desc.first))))
        else $error("popped descriptor did not load its head byte");
`endif

endmodule

// ===== sv/cte_front.sv =====
// Front end: classifies a token and builds its head descriptor.
`timescale 1ns / 1ps

module cte_front (
    input  logic [cte_pkg::KIND_W-1:0]  kind,
    input  logic [cte_pkg::VALUE_W-1:0] int_value,
    input  logic [cte_pkg::VALUE_W-1:0] count,
    input  logic [cte_pkg::BYTE_W-1:0]  data_byte,
    output logic                        emits,
    output cte_pkg::desc_t              desc
);

    logic [2:0]                  major;
    logic [cte_pkg::VALUE_W-1:0] arg;
    logic                        is_head;
    logic [cte_pkg::BYTE_W-1:0]  single;

    always_comb begin
        major   = cte_pkg::MAJOR_UINT;
        arg     = count;
        is_head = 1'b0;
        single  = data_byte;
        emits   = 1'b1;
        unique case (kind)
            cte_pkg::KIND_INT: begin
                is_head = 1'b1;
                if (int_value[cte_pkg::VALUE_W-1]) begin
                    major = cte_pkg::MAJOR_NINT;
                    arg   = ~int_value;
                end else begin
                    arg   = int_value;
                end
            end
            cte_pkg::KIND_FALSE:     single = cte_pkg::SIMPLE_FALSE;
            cte_pkg::KIND_TRUE:      single = cte_pkg::SIMPLE_TRUE;
            cte_pkg::KIND_NULL:      single = cte_pkg::SIMPLE_NULL;
            cte_pkg::KIND_UNDEFINED: single = cte_pkg::SIMPLE_UNDEFINED;
            cte_pkg::KIND_BYTES_HDR: begin
                is_head = 1'b1;
                major   = cte_pkg::MAJOR_BYTES;
            end
            cte_pkg::KIND_TEXT_HDR: begin
                is_head = 1'b1;
                major   = cte_pkg::MAJOR_TEXT;
            end
            cte_pkg::KIND_ARRAY_HDR: begin
                is_head = 1'b1;
                major   = cte_pkg::MAJOR_ARRAY;
            end
            cte_pkg::KIND_MAP_HDR: begin
                is_head = 1'b1;
                major   = cte_pkg::MAJOR_MAP;
            end
            cte_pkg::KIND_PAYLOAD:   single = data_byte;
            default:                 emits  = 1'b0;
        endcase
    end

    always_comb begin
        desc.arg = arg;
        if (!is_head) begin
            desc.first  = single;
            desc.nbytes = 4'd0;
        end else if (arg < cte_pkg::IMM_LIMIT) begin
            desc.first  = {major, arg[4:0]};
            desc.nbytes = 4'd0;
        end else if (arg < cte_pkg::ARG1_LIMIT) begin
            desc.first  = {major, cte_pkg::AI_ARG1};
            desc.nbytes = 4'd1;
        end else if (arg < cte_pkg::ARG2_LIMIT) begin
            desc.first  = {major, cte_pkg::AI_ARG2};
            desc.nbytes = 4'd2;
        end else if (arg < cte_pkg::ARG4_LIMIT) begin
            desc.first  = {major, cte_pkg::AI_ARG4};
            desc.nbytes = 4'd4;
        end else begin
            desc.first  = {major, cte_pkg::AI_ARG8};
            desc.nbytes = 4'd8;
        end
    end

endmodule

// ===== sv/cte_queue.sv =====
// Descriptor queue between front end and serializer.
`timescale 1ns / 1ps

module cte_queue #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  cte_pkg::hs_t   push_hs_in,
    output logic           push_ready,
    input  cte_pkg::desc_t push_desc,
    output cte_pkg::hs_t   pop_hs_out,
    input  logic           pop_ready,
    output cte_pkg::desc_t pop_desc,
    output logic           full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    cte_pkg::desc_t mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full       = (cnt_reg == DEPTH_CNT);
    assign push_ready = !full;
    assign do_push    = push_hs_in.valid && push_hs_in.ready && !full;
    assign do_pop     = (cnt_reg != '0) && pop_ready;
    assign pop_hs_out.valid = (cnt_reg != '0);
    assign pop_hs_out.ready = !full;
    assign pop_desc   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== sv/cte_back.sv =====
// Serializer: emits head and argument bytes, one per cycle unless stalled, to the output register.
`timescale 1ns / 1ps

module cte_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  cte_pkg::desc_t             q_desc,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [cte_pkg::BYTE_W-1:0] m_out_byte,
    output logic                       m_last_byte,
    output cte_pkg::back_state_t       state
);

    cte_pkg::back_state_t        state_reg, state_next;
    logic [cte_pkg::VALUE_W-1:0] arg_reg, arg_next;
    logic [cte_pkg::NB_W-1:0]    rem_reg, rem_next;
    logic                        valid_reg, valid_next;
    logic [cte_pkg::BYTE_W-1:0]  byte_reg, byte_next;
    logic                        last_reg, last_next;
    logic                        load;
    logic [cte_pkg::NB_W-1:0]    rem_dec;

    assign load    = !valid_reg || m_ready;
    assign rem_dec = rem_reg - 1'b1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cte_pkg::BK_HEAD: begin
                if (load && q_valid && (q_desc.nbytes != '0)) begin
                    state_next = cte_pkg::BK_ARG;
                end
            end
            cte_pkg::BK_ARG: begin
                if (load && (rem_reg == 4'd1)) begin
                    state_next = cte_pkg::BK_HEAD;
                end
            end
            default: state_next = cte_pkg::BK_HEAD;
        endcase
    end

    always_comb begin
        q_pop      = 1'b0;
        arg_next   = arg_reg;
        rem_next   = rem_reg;
        valid_next = valid_reg && !m_ready;
        byte_next  = byte_reg;
        last_next  = last_reg;
        unique case (state_reg)
            cte_pkg::BK_HEAD: begin
                if (load && q_valid) begin
                    q_pop      = 1'b1;
                    arg_next   = q_desc.arg;
                    rem_next   = q_desc.nbytes;
                    valid_next = 1'b1;
                    byte_next  = q_desc.first;
                    last_next  = (q_desc.nbytes == '0);
                end
            end
            cte_pkg::BK_ARG: begin
                if (load) begin
                    rem_next   = rem_dec;
                    valid_next = 1'b1;
                    byte_next  = arg_reg[rem_dec[cte_pkg::IDX_W-1:0]*cte_pkg::BYTE_W
                                         +: cte_pkg::BYTE_W];
                    last_next  = (rem_reg == 4'd1);
                end
            end
            default: valid_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cte_pkg::BK_HEAD;
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        arg_reg  <= arg_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_last_byte = last_reg;
    assign state       = state_reg;

endmodule

// ===== tb/tb_cbor_token_encoder_unit.sv =====
// Self-checking testbench for the CBOR token encoder: random and directed tokens, byte checks.
`timescale 1ns / 1ps

module tb_cbor_token_encoder_unit;

    localparam int KIND_W  = cte_pkg::KIND_W;
    localparam int VALUE_W = cte_pkg::VALUE_W;
    localparam int BYTE_W  = cte_pkg::BYTE_W;

    localparam int STALL_LIMIT  = 2000;
    localparam int RX_HOLD_LEN  = 300;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] ival;
        logic [VALUE_W-1:0] cnt;
        logic [BYTE_W-1:0]  dbyte;
    } token_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } cbor_byte_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind;
    logic [VALUE_W-1:0]  s_int_value;
    logic [VALUE_W-1:0]  s_count;
    logic [BYTE_W-1:0]   s_data_byte;
    logic                m_valid;
    logic                m_ready;
    logic [BYTE_W-1:0]   m_out_byte;
    logic                m_last_byte;

    token_t     pending_tokens[$];
    cbor_byte_t expected_bytes[$];

    logic s_taken;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   rx_hold_left;
    int   tokens_queued;
    int   tokens_accepted;
    int   bytes_checked;
    int   error_count;
    int   stall_cycles;

    cbor_token_encoder_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_int_value (s_int_value),
        .s_count     (s_count),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

    always #6 aclk = ~aclk;

    function automatic void push_byte(logic [BYTE_W-1:0] b, logic last);
        cbor_byte_t e;
        e.data = b;
        e.last = last;
        expected_bytes.push_back(e);
    endfunction

    function automatic void push_head(logic [2:0] major, logic [VALUE_W-1:0] arg);
        int         nb;
        logic [4:0] ai;
        if (arg < cte_pkg::IMM_LIMIT) begin
            push_byte({major, arg[4:0]}, 1'b1);
            return;
        end else if (arg < cte_pkg::ARG1_LIMIT) begin
            ai = cte_pkg::AI_ARG1;
            nb = 1;
        end else if (arg < cte_pkg::ARG2_LIMIT) begin
            ai = cte_pkg::AI_ARG2;
            nb = 2;
        end else if (arg < cte_pkg::ARG4_LIMIT) begin
            ai = cte_pkg::AI_ARG4;
            nb = 4;
        end else begin
            ai = cte_pkg::AI_ARG8;
            nb = 8;
        end
        push_byte({major, ai}, 1'b0);
        for (int i = nb - 1; i >= 0; i--) begin
            push_byte(arg[8*i +: 8], i == 0);
        end
    endfunction

    function automatic void encode_token(token_t t);
        case (t.kind)
            cte_pkg::KIND_INT: begin
                if (!t.ival[VALUE_W-1]) push_head(cte_pkg::MAJOR_UINT, t.ival);
                else push_head(cte_pkg::MAJOR_NINT, ~t.ival);
            end
            cte_pkg::KIND_FALSE:     push_byte(cte_pkg::SIMPLE_FALSE, 1'b1);
            cte_pkg::KIND_TRUE:      push_byte(cte_pkg::SIMPLE_TRUE, 1'b1);
            cte_pkg::KIND_NULL:      push_byte(cte_pkg::SIMPLE_NULL, 1'b1);
            cte_pkg::KIND_UNDEFINED: push_byte(cte_pkg::SIMPLE_UNDEFINED, 1'b1);
            cte_pkg::KIND_BYTES_HDR: push_head(cte_pkg::MAJOR_BYTES, t.cnt);
            cte_pkg::KIND_TEXT_HDR:  push_head(cte_pkg::MAJOR_TEXT, t.cnt);
            cte_pkg::KIND_ARRAY_HDR: push_head(cte_pkg::MAJOR_ARRAY, t.cnt);
            cte_pkg::KIND_MAP_HDR:   push_head(cte_pkg::MAJOR_MAP, t.cnt);
            cte_pkg::KIND_PAYLOAD:   push_byte(t.dbyte, 1'b1);
            default: ;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VALUE_W-1:0] rand_arg(int width_class);
        case (width_class)
            0:       return VALUE_W'($urandom_range(23));
            1:       return VALUE_W'($urandom_range(255, 24));
            2:       return VALUE_W'($urandom_range(65535, 256));
            3:       return VALUE_W'($urandom_range(32'hffff_ffff, 65536));
            default: return {$urandom_range(32'hffff_ffff, 1), $urandom};
        endcase
    endfunction

    task automatic queue_token(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] ival,
                               logic [VALUE_W-1:0] cnt, logic [BYTE_W-1:0] dbyte);
        token_t t;
        t.kind  = kind;
        t.ival  = ival;
        t.cnt   = cnt;
        t.dbyte = dbyte;
        pending_tokens.push_back(t);
        tokens_queued++;
    endtask

    task automatic queue_random(int n);
        int                 added;
        int                 pick;
        int                 len;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] arg;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                queue_token(KIND_W'($urandom_range(15, 10)), rand64(), rand64(),
                            BYTE_W'($urandom));
                added++;
            end else if (pick < 20) begin
                len = $urandom_range(4);
                kind = ($urandom_range(1) != 0) ? cte_pkg::KIND_TEXT_HDR
                                                : cte_pkg::KIND_BYTES_HDR;
                queue_token(kind, rand64(), VALUE_W'(len), BYTE_W'($urandom));
                for (int i = 0; i < len; i++) begin
                    queue_token(cte_pkg::KIND_PAYLOAD, rand64(), rand64(),
                                BYTE_W'($urandom));
                end
                added += len + 1;
            end else begin
                kind = KIND_W'($urandom_range(9));
                arg = rand_arg($urandom_range(4));
                if (kind == cte_pkg::KIND_INT) begin
                    arg[VALUE_W-1] = 1'b0;
                    if ($urandom_range(1) != 0) arg = ~arg;
                    queue_token(kind, arg, rand64(), BYTE_W'($urandom));
                end else begin
                    queue_token(kind, rand64(), arg, BYTE_W'($urandom));
                end
                added++;
            end
        end
    endtask

    task automatic settle();
        while (tokens_accepted != tokens_queued) @(posedge aclk);
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(negedge aclk) begin : drive_tokens
        token_t t;
        if (!s_valid || s_taken) begin
            if (pending_tokens.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                t = pending_tokens.pop_front();
                s_valid     <= 1'b1;
                s_kind      <= t.kind;
                s_int_value <= t.ival;
                s_count     <= t.cnt;
                s_data_byte <= t.dbyte;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : drive_ready
        if (rx_hold_left > 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : observe
        token_t     t;
        cbor_byte_t e;
        s_taken = 1'b0;
        if (aresetn) begin
            stall_cycles++;
            if (s_valid && s_ready) begin
                s_taken = 1'b1;
                t.kind  = s_kind;
                t.ival  = s_int_value;
                t.cnt   = s_count;
                t.dbyte = s_data_byte;
                encode_token(t);
                tokens_accepted++;
                stall_cycles = 0;
            end
            if (m_valid && m_ready) begin
                stall_cycles = 0;
                if (expected_bytes.size() == 0) begin
                    $error("unexpected item: out_byte %02h last_byte %0b",
                           m_out_byte, m_last_byte);
                    error_count++;
                end else begin
                    e = expected_bytes.pop_front();
                    bytes_checked++;
                    if (m_out_byte !== e.data) begin
                        $error("out_byte: expected %02h, actual %02h", e.data, m_out_byte);
                        error_count++;
                    end
                    if (m_last_byte !== e.last) begin
                        $error("last_byte: expected %0b, actual %0b", e.last, m_last_byte);
                        error_count++;
                    end
                end
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("tb_cbor_token_encoder_unit failed");
                $finish;
            end
        end
    end

    initial begin
        aclk            = 1'b0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_kind          = '0;
        s_int_value     = '0;
        s_count         = '0;
        s_data_byte     = '0;
        m_ready         = 1'b0;
        s_taken         = 1'b0;
        tx_idle_pct     = 36;
        rx_idle_pct     = 47;
        rx_hold_left    = 0;
        tokens_queued   = 0;
        tokens_accepted = 0;
        bytes_checked   = 0;
        error_count     = 0;
        stall_cycles    = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        queue_token(cte_pkg::KIND_INT, 64'd0, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_INT, 64'd23, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_INT, 64'd24, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_INT, 64'd255, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_INT, 64'd256, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_INT, 64'd65535, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_INT, 64'd65536, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_INT, 64'hffff_ffff, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_INT, 64'h1_0000_0000, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_INT, 64'h7fff_ffff_ffff_ffff, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_INT, ~64'd0, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_INT, ~64'd23, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_INT, ~64'd24, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_INT, 64'h8000_0000_0000_0000, rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_FALSE, rand64(), rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_TRUE, rand64(), rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_NULL, rand64(), rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_UNDEFINED, rand64(), rand64(), BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_BYTES_HDR, rand64(), 64'd0, BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_TEXT_HDR, rand64(), 64'd23, BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_ARRAY_HDR, rand64(), ~64'd0, BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_MAP_HDR, rand64(), 64'd24, BYTE_W'($urandom));
        queue_token(cte_pkg::KIND_PAYLOAD, rand64(), rand64(), 8'h00);
        queue_token(cte_pkg::KIND_PAYLOAD, rand64(), rand64(), 8'hff);
        queue_token(4'd10, rand64(), rand64(), BYTE_W'($urandom));
        queue_token(4'd15, rand64(), rand64(), BYTE_W'($urandom));
        queue_random(50);
        settle();

        tx_idle_pct  = 0;
        rx_hold_left = RX_HOLD_LEN;
        for (int i = 0; i < 24; i++) begin
            queue_token(cte_pkg::KIND_INT, rand_arg(4) >> 1, rand64(), BYTE_W'($urandom));
        end
        settle();

        tx_idle_pct = 47;
        rx_idle_pct = 36;
        queue_random(45);
        settle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random(25);
        settle();

        $display("covered %0d tokens (all kinds, every head width, both signs), %0d bytes checked",
                 tokens_accepted, bytes_checked);
        $display("idle mixes: sender-heavy, receiver-heavy, none; one long receiver hold-off");
        if (error_count == 0) begin
            $display("tb_cbor_token_encoder_unit passed");
        end else begin
            $display("tb_cbor_token_encoder_unit failed");
        end
        $finish;
    end

endmodule
